[rtl/assert_macros.svh]
// assertion macros used by the top-level parser rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HHLP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define HHLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define HHLP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define HHLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/hhlp_pkg.sv]
// types, codes and character classes of the header line parser
package hhlp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] name_start;
    logic [15:0] name_stop;
    logic [15:0] value_start;
    logic [15:0] value_stop;
    logic [1:0]  end_status;
  } out_item_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_END    = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NUL     = 2'd1;
  localparam logic [1:0] STATUS_NO_CRLF = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    logic ok;
    ok = 1'b1;
    if (c >= CHAR_DEL || c <= CHAR_SPACE) begin
      ok = 1'b0;
    end else begin
      case (c)
        8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
        8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: begin
          ok = 1'b0;
        end
        default: begin
          ok = 1'b1;
        end
      endcase
    end
    return ok;
  endfunction

endpackage

[rtl/hhlp_line_state.sv]
// running line state and result forming, one byte per advance
module hhlp_line_state import hhlp_pkg::*; #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_item_t  item,
  output logic      result_valid,
  output out_item_t result
);

  localparam int OW = OFFSET_WIDTH;

  logic [OW-1:0] byte_position_r, byte_position_nxt;
  logic          line_open_r, line_open_nxt;
  logic [OW-1:0] line_begin_r, line_begin_nxt;
  logic          colon_seen_r, colon_seen_nxt;
  logic          name_bad_r, name_bad_nxt;
  logic          name_blank_pending_r, name_blank_pending_nxt;
  logic [OW-1:0] name_trim_end_r, name_trim_end_nxt;
  logic [OW-1:0] value_first_r, value_first_nxt;
  logic [OW-1:0] value_trim_end_r, value_trim_end_nxt;
  logic          value_has_text_r, value_has_text_nxt;
  logic          value_nul_r, value_nul_nxt;
  logic          stopped_error_r, stopped_error_nxt;
  logic [7:0]    previous_byte_r, previous_byte_nxt;

  logic [7:0]    c;
  logic [OW-1:0] pos, next_pos;
  logic          blank, line_end;

  assign c        = item.data_byte;
  assign pos      = byte_position_r;
  assign next_pos = byte_position_r + OW'(1);
  assign blank    = is_blank(c);
  assign line_end = (c == CHAR_CR) || (c == CHAR_LF);

  always_comb begin
    byte_position_nxt      = byte_position_r;
    line_open_nxt          = line_open_r;
    line_begin_nxt         = line_begin_r;
    colon_seen_nxt         = colon_seen_r;
    name_bad_nxt           = name_bad_r;
    name_blank_pending_nxt = name_blank_pending_r;
    name_trim_end_nxt      = name_trim_end_r;
    value_first_nxt        = value_first_r;
    value_trim_end_nxt     = value_trim_end_r;
    value_has_text_nxt     = value_has_text_r;
    value_nul_nxt          = value_nul_r;
    stopped_error_nxt      = stopped_error_r;
    previous_byte_nxt      = previous_byte_r;
    result_valid           = 1'b0;
    result                 = '0;

    if (item.last_byte) begin
      // end of buffer: report status, then everything back to reset
      result_valid       = 1'b1;
      result.result_kind = KIND_END;
      if (!(c == CHAR_LF && previous_byte_r == CHAR_CR)) begin
        result.end_status = STATUS_NO_CRLF;
      end else if (stopped_error_r) begin
        result.end_status = STATUS_NUL;
      end else begin
        result.end_status = STATUS_OK;
      end
      byte_position_nxt      = '0;
      line_open_nxt          = 1'b0;
      line_begin_nxt         = '0;
      colon_seen_nxt         = 1'b0;
      name_bad_nxt           = 1'b0;
      name_blank_pending_nxt = 1'b0;
      name_trim_end_nxt      = '0;
      value_first_nxt        = '0;
      value_trim_end_nxt     = '0;
      value_has_text_nxt     = 1'b0;
      value_nul_nxt          = 1'b0;
      stopped_error_nxt      = 1'b0;
      previous_byte_nxt      = '0;
    end else begin
      if (line_end) begin
        if (line_open_r && !stopped_error_r && colon_seen_r && !name_bad_r) begin
          if (value_nul_r) begin
            stopped_error_nxt = 1'b1;
          end else begin
            result_valid       = 1'b1;
            result.result_kind = KIND_HEADER;
            result.name_start  = 16'(line_begin_r);
            result.name_stop   = 16'(name_trim_end_r);
            result.value_start = value_has_text_r ? 16'(value_first_r) : 16'(pos);
            result.value_stop  = value_has_text_r ? 16'(value_trim_end_r) : 16'(pos);
            result.end_status  = STATUS_OK;
          end
        end
        line_open_nxt = 1'b0;
      end else begin
        if (!line_open_r) begin
          // first byte of a new line
          line_open_nxt          = 1'b1;
          line_begin_nxt         = pos;
          colon_seen_nxt         = 1'b0;
          name_blank_pending_nxt = 1'b0;
          name_trim_end_nxt      = pos;
          value_first_nxt        = '0;
          value_trim_end_nxt     = '0;
          value_has_text_nxt     = 1'b0;
          value_nul_nxt          = 1'b0;
          name_bad_nxt           = blank || (c == CHAR_COLON);
        end
        if (!colon_seen_nxt) begin
          if (c == CHAR_COLON) begin
            colon_seen_nxt = 1'b1;
          end else if (blank) begin
            name_blank_pending_nxt = 1'b1;
          end else begin
            if (name_blank_pending_nxt || !is_token(c)) begin
              name_bad_nxt = 1'b1;
            end
            name_blank_pending_nxt = 1'b0;
            name_trim_end_nxt      = next_pos;
          end
        end else begin
          if (c == CHAR_NUL) begin
            value_nul_nxt = 1'b1;
          end
          if (!blank) begin
            if (!value_has_text_nxt) begin
              value_first_nxt = pos;
            end
            value_has_text_nxt = 1'b1;
            value_trim_end_nxt = next_pos;
          end
        end
      end
      previous_byte_nxt = c;
      byte_position_nxt = next_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r      <= '0;
      line_open_r          <= 1'b0;
      line_begin_r         <= '0;
      colon_seen_r         <= 1'b0;
      name_bad_r           <= 1'b0;
      name_blank_pending_r <= 1'b0;
      name_trim_end_r      <= '0;
      value_first_r        <= '0;
      value_trim_end_r     <= '0;
      value_has_text_r     <= 1'b0;
      value_nul_r          <= 1'b0;
      stopped_error_r      <= 1'b0;
      previous_byte_r      <= '0;
    end else if (advance) begin
      byte_position_r      <= byte_position_nxt;
      line_open_r          <= line_open_nxt;
      line_begin_r         <= line_begin_nxt;
      colon_seen_r         <= colon_seen_nxt;
      name_bad_r           <= name_bad_nxt;
      name_blank_pending_r <= name_blank_pending_nxt;
      name_trim_end_r      <= name_trim_end_nxt;
      value_first_r        <= value_first_nxt;
      value_trim_end_r     <= value_trim_end_nxt;
      value_has_text_r     <= value_has_text_nxt;
      value_nul_r          <= value_nul_nxt;
      stopped_error_r      <= stopped_error_nxt;
      previous_byte_r      <= previous_byte_nxt;
    end
  end

endmodule

[rtl/http_header_line_parser.sv]
// http header line parser: one byte per transaction, header offsets and end status out
// each byte is held in the input register; its result is registered in the result register once that is free
// throughput: one byte per cycle, sustained while out_stall stays low
// an input register and a result register part the two sides
// reset: synchronous active-low rst_n empties both registers and clears line state
`include "assert_macros.svh"
module http_header_line_parser import hhlp_pkg::*; #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register stage
  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_data_r;

  // result register stage
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic      out_free;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  // the result register can take a new transaction when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  // the held byte updates line state only when its result has somewhere to go
  assign advance  = in_valid_r && out_free;
  // the input register holds its byte while a finished result still waits
  assign in_stall = in_valid_r && !out_free;

  assign in_valid_nxt  = in_stall ? in_valid_r : in_valid;
  assign out_valid_nxt = out_free ? (advance && res_valid) : 1'b1;

  hhlp_line_state #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_line_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .item         (in_data_r),
    .result_valid (res_valid),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a stall toward the source only comes from a full input register
  `HHLP_ASSERT_IMPLIES(a_stall_needs_item, clk, rst_n, in_stall, in_valid_r)
  // end results carry zero offsets
  `HHLP_ASSERT_IMPLIES(a_end_zero_offsets, clk, rst_n,
    out_valid_r && out_data_r.result_kind == KIND_END,
    out_data_r.name_start == 16'd0 && out_data_r.value_stop == 16'd0)
  // header results always carry an ok status
  `HHLP_ASSERT_IMPLIES(a_header_status_ok, clk, rst_n,
    out_valid_r && out_data_r.result_kind == KIND_HEADER,
    out_data_r.end_status == STATUS_OK)
  // only defined status codes leave the block
  `HHLP_ASSERT_IMPLIES(a_status_defined, clk, rst_n, out_valid_r,
    out_data_r.end_status == STATUS_OK || out_data_r.end_status == STATUS_NUL ||
    out_data_r.end_status == STATUS_NO_CRLF)

endmodule

[tb/tb_top.sv]
// self-checking testbench for the http header line parser: directed, random and noise tests
`timescale 1ns / 1ps

module tb_top;
  import hhlp_pkg::*;

  // cycles with no transaction on either side before the run is called hung
  localparam int WATCHDOG_LIMIT = 4000;
  // result register depth plus margin, waited out before the verdict
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_REPORTS    = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  http_header_line_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // results the parser owes us, oldest first
  out_item_t pending_results[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        bytes_sent = 0;

  // sender burst control
  bit        bursty = 1'b1;
  int        burst_left = 0;

  // ---------------------------------------------------------------------------
  // line parser prediction, same running state the block keeps
  // ---------------------------------------------------------------------------
  logic [15:0] cur_offset;
  logic        in_line;
  logic [15:0] line_start;
  logic        got_colon;
  logic        name_broken;
  logic        blank_after_name;
  logic [15:0] name_stop_pos;
  logic [15:0] val_begin;
  logic [15:0] val_end;
  logic        val_nonblank;
  logic        val_has_nul;
  logic        parse_halted;
  logic [7:0]  last_char;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  // token characters: printable ascii minus the separators ( ) < > @ , ; : \ " / [ ] ? = { }
  function automatic logic token_char(input logic [7:0] c);
    if (c <= CHAR_SPACE || c >= CHAR_DEL) return 1'b0;
    return !(c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
                       8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D});
  endfunction

  task automatic clear_parser_state();
    cur_offset       = '0;
    in_line          = 1'b0;
    line_start       = '0;
    got_colon        = 1'b0;
    name_broken      = 1'b0;
    blank_after_name = 1'b0;
    name_stop_pos    = '0;
    val_begin        = '0;
    val_end          = '0;
    val_nonblank     = 1'b0;
    val_has_nul      = 1'b0;
    parse_halted     = 1'b0;
    last_char        = '0;
  endtask

  // one accepted byte; queues the result it causes, if any
  task automatic parse_model_byte(input in_item_t t);
    out_item_t   r;
    logic [7:0]  c;
    logic [15:0] nxt;
    c   = t.data_byte;
    nxt = cur_offset + 16'd1;   // 16-bit offsets wrap on their own
    r   = '0;
    if (t.last_byte) begin
      // end of buffer: missing crlf wins over a nul value
      r.result_kind = KIND_END;
      if (!(c == CHAR_LF && last_char == CHAR_CR)) r.end_status = STATUS_NO_CRLF;
      else if (parse_halted)                       r.end_status = STATUS_NUL;
      else                                         r.end_status = STATUS_OK;
      pending_results = {pending_results, r};
      clear_parser_state();
    end else begin
      if (c == CHAR_CR || c == CHAR_LF) begin
        // line end: report only a well-formed line while parsing still runs
        if (in_line && !parse_halted && got_colon && !name_broken) begin
          if (val_has_nul) begin
            parse_halted = 1'b1;
          end else begin
            r.result_kind = KIND_HEADER;
            r.name_start  = line_start;
            r.name_stop   = name_stop_pos;
            r.value_start = val_nonblank ? val_begin : cur_offset;
            r.value_stop  = val_nonblank ? val_end : cur_offset;
            pending_results = {pending_results, r};
          end
        end
        in_line = 1'b0;
      end else begin
        if (!in_line) begin
          in_line          = 1'b1;
          line_start       = cur_offset;
          got_colon        = 1'b0;
          blank_after_name = 1'b0;
          name_stop_pos    = cur_offset;
          val_begin        = '0;
          val_end          = '0;
          val_nonblank     = 1'b0;
          val_has_nul      = 1'b0;
          // empty name or leading blank
          name_broken      = blank_char(c) || (c == CHAR_COLON);
        end
        if (!got_colon) begin
          if (c == CHAR_COLON) begin
            got_colon = 1'b1;
          end else if (blank_char(c)) begin
            blank_after_name = 1'b1;
          end else begin
            // a blank inside the name or a non-token byte breaks it
            if (blank_after_name || !token_char(c)) name_broken = 1'b1;
            blank_after_name = 1'b0;
            name_stop_pos    = nxt;
          end
        end else begin
          if (c == CHAR_NUL) val_has_nul = 1'b1;
          if (!blank_char(c)) begin
            if (!val_nonblank) val_begin = cur_offset;
            val_nonblank = 1'b1;
            val_end      = nxt;
          end
        end
      end
      last_char  = c;
      cur_offset = nxt;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side: one transaction per call, bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        // only lower valid when a real gap follows, never lower and raise in one step
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    // in_stall read right after the edge is the value the block sampled
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    parse_model_byte('{data_byte: b, last_byte: last});
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // sender holds off until every owed result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] rand_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!token_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
  endfunction

  task automatic send_line_end();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_byte(CHAR_CR, 1'b0);
      send_byte(CHAR_LF, 1'b0);
    end else if (r < 85) begin
      send_byte(CHAR_LF, 1'b0);
    end else begin
      send_byte(CHAR_CR, 1'b0);
    end
  endtask

  // mostly valid header line, now and then with a flawed name or a nul value
  task automatic send_header_line();
    int         flaw;
    int         n;
    int         vlen;
    int         nul_at;
    logic [7:0] c;
    flaw   = $urandom_range(0, 11);
    n      = (flaw == 3) ? 0 : $urandom_range(1, 6);
    vlen   = $urandom_range(0, 8);
    nul_at = ($urandom_range(0, 39) == 0) ? $urandom_range(0, vlen) : -1;
    if (flaw == 0) send_byte(rand_blank(), 1'b0);
    for (int i = 0; i < n; i++) begin
      send_byte(rand_token(), 1'b0);
      if (flaw == 1 && i == 0) begin
        do c = 8'($urandom); while (c == CHAR_CR || c == CHAR_LF);
        send_byte(c, 1'b0);
      end
      if (flaw == 2 && i == 0 && n > 1) send_byte(rand_blank(), 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    send_byte(CHAR_COLON, 1'b0);
    repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    for (int i = 0; i <= vlen; i++) begin
      if (i == nul_at) send_byte(CHAR_NUL, 1'b0);
      if (i == vlen) break;
      if ($urandom_range(0, 9) == 0) send_byte(rand_blank(), 1'b0);
      else                           send_byte(8'($urandom_range(33, 255)), 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_byte(rand_blank(), 1'b0);
    send_line_end();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes and each special case on short hand-made buffers
  task automatic test_directed_cases();
    // trailing blank trimmed from the name, empty value, clean crlf end
    send_text("a :\r");
    send_byte(CHAR_LF, 1'b1);
    // name starts with a tab: skipped, its nul does not halt parsing
    send_text("\t:");
    send_byte(CHAR_NUL, 1'b0);
    send_text("\r");
    send_byte(CHAR_LF, 1'b1);
    // nul value halts, the next good line is dropped, nul status
    send_text("c:");
    send_byte(CHAR_NUL, 1'b0);
    send_text("\nd:e\r");
    send_byte(CHAR_LF, 1'b1);
    // one-byte buffer never ends in crlf
    send_byte(8'hFF, 1'b1);
    // 0xff in a value, empty line skipped, del in a name, buffer ends in a lone cr: no crlf status
    send_text("x: ");
    send_byte(8'hFF, 1'b0);
    send_text(" \n\r\n");
    send_byte(CHAR_DEL, 1'b0);
    send_text(":y");
    send_byte(CHAR_CR, 1'b1);
    // nul value and missing crlf together: missing crlf wins
    send_text("k:");
    send_byte(CHAR_NUL, 1'b0);
    send_text("\n");
    send_byte(8'h00, 1'b1);
  endtask

  // buffers of random header lines, some broken lines and buffer ends without crlf mixed in
  task automatic test_random_headers();
    int start;
    int lines;
    int r;
    int nbuf;
    start = bytes_sent;
    nbuf  = 0;
    while (bytes_sent - start < 1250) begin
      bursty = ($urandom_range(0, 4) != 0);
      lines  = $urandom_range(1, 8);
      repeat (lines) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_header_line();
        end else if (r < 80) begin
          send_byte(CHAR_CR, 1'b0);
          send_byte(CHAR_LF, 1'b0);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 10)) send_byte(rand_token(), 1'b0);
          send_line_end();
        end else begin
          repeat ($urandom_range(1, 10)) send_byte(8'($urandom), 1'b0);
          send_byte(CHAR_LF, 1'b0);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b1);
      end else if (r < 92) begin
        send_byte(CHAR_LF, 1'b1);
      end else begin
        send_byte(8'($urandom), 1'b1);
      end
      nbuf++;
      if (nbuf == 3 || $urandom_range(0, 7) == 0) wait_for_results();
    end
    bursty = 1'b1;
  endtask

  // raw bytes with the last flag set now and then
  task automatic test_noise_bytes();
    repeat (250) send_byte(8'($urandom), ($urandom_range(0, 29) == 0));
    send_byte(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    int mode;
    int run;
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 200);
      for (int i = 0; i < run; i++) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            out_stall <= ((i % 7) < 3);
          end
        endcase
      end
    end
  end

  function automatic string fmt_result(input out_item_t r);
    return $sformatf("kind=%0d name=%0d..%0d value=%0d..%0d status=%0d",
                     r.result_kind, r.name_start, r.name_stop,
                     r.value_start, r.value_stop, r.end_status);
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result %s", fmt_result(out_data)));
        end else begin
          want = pending_results.pop_front();
          if (out_data.result_kind !== want.result_kind ||
              out_data.name_start  !== want.name_start  ||
              out_data.name_stop   !== want.name_stop   ||
              out_data.value_start !== want.value_start ||
              out_data.value_stop  !== want.value_stop  ||
              out_data.end_status  !== want.end_status) begin
            report_failure($sformatf("expected %s, got %s",
                                     fmt_result(want), fmt_result(out_data)));
          end
        end
      end
      // any transaction on either side counts as progress
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    wait_for_results();
    test_random_headers();
    test_noise_bytes();

    // drain, then let the result register settle before the verdict
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/hhlp_pkg.sv
rtl/hhlp_line_state.sv
rtl/http_header_line_parser.sv
tb/tb_top.sv
